// ===== rtl/sast_pkg.sv =====
// shared types and codes for the two-stacks-in-one-array block
// no dependencies; imported by every module of the block
package sast_pkg;

  localparam int unsigned WordW = 32;

  // operation and side codes of an input beat
  localparam logic ModePush = 1'b0;
  localparam logic ModePop  = 1'b1;
  localparam logic SideLeft  = 1'b0;
  localparam logic SideRight = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // classified operation handed from front to back
  typedef struct packed {
    logic    wr;
    logic    rd;
    status_e status;
  } op_t;

endpackage

// ===== rtl/sast_front.sv =====
// front end: accepts operations, checks full/empty, tracks both stack counts
// depends on sast_pkg
module sast_front import sast_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic                       side_i,
  input  logic signed [WordW-1:0]    push_value_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output op_t                        cmd_op_o,
  output logic [$clog2(DEPTH)-1:0]   cmd_addr_o,
  output logic [WordW-1:0]           cmd_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DepthExt = (CW + 1)'(DEPTH);

  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] right_q, right_d;
  logic          accept;
  logic [CW:0]   used;
  logic [CW:0]   addr_wide;
  op_t           op;

  assign in_ready_o  = cmd_ready_i;
  assign accept      = in_valid_i && cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign cmd_data_o  = push_value_i;
  assign used        = {1'b0, left_q} + {1'b0, right_q};

  // classify the beat and pick the store entry
  always_comb begin
    op        = '{wr: 1'b0, rd: 1'b0, status: ST_OK};
    addr_wide = '0;
    left_d    = left_q;
    right_d   = right_q;
    if (mode_i == ModePush) begin
      if (used >= DepthExt) begin
        op.status = ST_FULL;
      end else if (side_i == SideLeft) begin
        op.wr     = 1'b1;
        addr_wide = {1'b0, left_q};
        left_d    = left_q + 1'b1;
      end else begin
        op.wr     = 1'b1;
        addr_wide = DepthExt - (CW + 1)'(1) - {1'b0, right_q};
        right_d   = right_q + 1'b1;
      end
    end else begin
      if (side_i == SideLeft) begin
        if (left_q == '0) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd     = 1'b1;
          addr_wide = {1'b0, left_q} - (CW + 1)'(1);
          left_d    = left_q - 1'b1;
        end
      end else begin
        if (right_q == '0) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd     = 1'b1;
          addr_wide = DepthExt - {1'b0, right_q};
          right_d   = right_q - 1'b1;
        end
      end
    end
  end

  assign cmd_op_o   = op;
  assign cmd_addr_o = addr_wide[AW-1:0];

  // stack counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else if (accept) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

endmodule

// ===== rtl/sast_fifo.sv =====
// two-entry queue between front and back
// depends on sast_pkg for the WordW default width only
module sast_fifo import sast_pkg::*; #(
  parameter int unsigned WIDTH = WordW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = slot_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== rtl/sast_back.sv =====
// back end: word store access and result register
// depends on sast_pkg
module sast_back import sast_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  op_t                        cmd_op_i,
  input  logic [$clog2(DEPTH)-1:0]   cmd_addr_i,
  input  logic [WordW-1:0]           cmd_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [WordW-1:0]    pop_value_o,
  output logic [1:0]                 status_o
);

  logic [WordW-1:0] mem_q [DEPTH];
  logic [WordW-1:0] rdata_q;
  logic             out_valid_q;
  logic             is_pop_q;
  status_e          status_q;
  logic             issue;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign issue       = cmd_valid_i && cmd_ready_o;

  // word store, at most one access per beat
  always_ff @(posedge clk_i) begin
    if (issue && cmd_op_i.wr) mem_q[cmd_addr_i] <= cmd_data_i;
    if (issue && cmd_op_i.rd) rdata_q <= mem_q[cmd_addr_i];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      out_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      is_pop_q <= cmd_op_i.rd;
      status_q <= cmd_op_i.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pop_value_o = is_pop_q ? rdata_q : '0;
  assign status_o    = status_q;

endmodule

// ===== rtl/shared_array_two_stacks.sv =====
// Two LIFO stacks sharing one store of DEPTH 32-bit words: the left stack fills
// from entry 0 upward, the right stack from entry DEPTH-1 downward. Each input
// beat is a push or pop on one side and returns exactly one result beat: the
// popped word (a zero word for a push) with status ok, or status full (push while
// both stacks hold DEPTH words in total) or empty (pop of an empty side), with
// state unchanged and a zero word. The front checks counts and picks the entry in
// the accept cycle, a two-entry queue decouples it from the back, which does the
// store access, if any, and holds the result. Sustained rate is one beat per
// cycle while out_ready_i stays high, set by the one store port; an accepted beat
// is registered in the queue and then in the result register before result valid
// rises. The store is not cleared at reset; no clearing pass is needed.
// depends on sast_pkg, sast_front, sast_fifo, sast_back
module shared_array_two_stacks import sast_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic                    side_i,
  input  logic signed [WordW-1:0] push_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [WordW-1:0] pop_value_o,
  output logic [1:0]              status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned QW = $bits(op_t) + AW + WordW;

  logic             f_valid, f_ready;
  op_t              f_op;
  logic [AW-1:0]    f_addr;
  logic [WordW-1:0] f_data;
  logic             b_valid, b_ready;
  op_t              b_op;
  logic [AW-1:0]    b_addr;
  logic [WordW-1:0] b_data;
  logic [QW-1:0]    q_in, q_out;

  sast_front #(.DEPTH(DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .side_i       (side_i),
    .push_value_i (push_value_i),
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready),
    .cmd_op_o     (f_op),
    .cmd_addr_o   (f_addr),
    .cmd_data_o   (f_data)
  );

  // pack commands through the queue
  assign q_in = {f_op, f_addr, f_data};
  assign {b_op, b_addr, b_data} = q_out;

  sast_fifo #(.WIDTH(QW)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (q_in),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (q_out)
  );

  sast_back #(.DEPTH(DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_op_i    (b_op),
    .cmd_addr_i  (b_addr),
    .cmd_data_i  (b_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pop_value_o (pop_value_o),
    .status_o    (status_o)
  );

endmodule
